@@ rtl/eul_rot_pkg.sv @@
package eul_rot_pkg;

  localparam int ANGLE_BITS = 16;
  localparam int FRAC_BITS = 14;
  localparam int OUT_BITS = FRAC_BITS + 2;
  localparam int CORDIC_STEPS = 30;
  localparam int ZW = 34;
  localparam int XW = 34;
  localparam int PW = 2 * OUT_BITS;

  localparam logic signed [XW-1:0] K_Q30 = XW'(652032874);
  localparam logic [31:0] PI_Q30 = 32'd3373259426;
  localparam logic signed [OUT_BITS-1:0] ONE = OUT_BITS'(1 << FRAC_BITS);

  typedef logic [ANGLE_BITS-1:0] angle_t;
  typedef logic signed [OUT_BITS-1:0] q_t;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic [1:0] quad;
  } cordic_t;

  typedef struct packed {
    q_t c;
    q_t s;
  } sc_t;

  function automatic logic signed [ZW-1:0] atan_q30(input int i);
    logic [29:0] t;
    case (i)
      0: t = 30'd843314856;
      1: t = 30'd497837829;
      2: t = 30'd263043836;
      3: t = 30'd133525158;
      4: t = 30'd67021686;
      5: t = 30'd33543515;
      6: t = 30'd16775850;
      7: t = 30'd8388437;
      8: t = 30'd4194282;
      9: t = 30'd2097149;
      10: t = 30'd1048575;
      11: t = 30'd524287;
      12: t = 30'd262143;
      13: t = 30'd131071;
      14: t = 30'd65535;
      15: t = 30'd32767;
      16: t = 30'd16383;
      17: t = 30'd8191;
      18: t = 30'd4095;
      19: t = 30'd2047;
      20: t = 30'd1023;
      21: t = 30'd511;
      22: t = 30'd255;
      23: t = 30'd127;
      24: t = 30'd63;
      25: t = 30'd31;
      26: t = 30'd15;
      27: t = 30'd7;
      28: t = 30'd3;
      29: t = 30'd1;
      default: t = 30'd0;
    endcase
    return ZW'(t);
  endfunction

  function automatic q_t sat_one(input logic signed [XW-1:0] v);
    if (v > XW'(1 << FRAC_BITS)) return ONE;
    if (v < -XW'(1 << FRAC_BITS)) return -ONE;
    return OUT_BITS'(v);
  endfunction

  function automatic q_t q30_to_frac(input logic signed [XW-1:0] v);
    logic signed [XW-1:0] r;
    r = (v + XW'(1 << (30 - FRAC_BITS - 1))) >>> (30 - FRAC_BITS);
    return sat_one(r);
  endfunction

  function automatic q_t mulq(input q_t a, input q_t b);
    logic signed [PW-1:0] p;
    p = (PW'(a) * PW'(b) + PW'(1 << (FRAC_BITS - 1))) >>> FRAC_BITS;
    return OUT_BITS'(p);
  endfunction

  function automatic q_t sat_sum(input logic signed [OUT_BITS+1:0] v);
    if (v > (OUT_BITS+2)'(1 << FRAC_BITS)) return ONE;
    if (v < -(OUT_BITS+2)'(1 << FRAC_BITS)) return -ONE;
    return OUT_BITS'(v);
  endfunction

endpackage

@@ rtl/eul_rot_if.sv @@
interface eul_rot_in_if;
  logic valid;
  logic ready;
  eul_rot_pkg::angle_t pitch_angle;
  eul_rot_pkg::angle_t yaw_angle;
  eul_rot_pkg::angle_t roll_angle;
  modport source(output valid, pitch_angle, yaw_angle, roll_angle, input ready);
  modport sink(input valid, pitch_angle, yaw_angle, roll_angle, output ready);
endinterface

interface eul_rot_out_if;
  logic valid;
  logic ready;
  eul_rot_pkg::q_t r00, r01, r02, r10, r11, r12, r20, r21, r22;
  modport source(output valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                 input ready);
  modport sink(input valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
               output ready);
endinterface

@@ rtl/eul_rot_cordic.sv @@
// One CORDIC lane: angle setup stage, 30 rotation stages, output stage.
module eul_rot_cordic (
  input  logic                clk,
  input  logic                en,
  input  eul_rot_pkg::angle_t angle,
  output eul_rot_pkg::sc_t    sc
);
  localparam int N = eul_rot_pkg::CORDIC_STEPS;

  eul_rot_pkg::cordic_t st [N+1];
  logic [31:0] t;
  logic [61:0] zp;
  eul_rot_pkg::q_t cc, ss;

  assign t = {angle, (32 - eul_rot_pkg::ANGLE_BITS)'(0)};
  assign zp = 62'(t[29:0]) * 62'(eul_rot_pkg::PI_Q30);

  always_ff @(posedge clk) begin
    if (en) begin
      st[0].x <= eul_rot_pkg::K_Q30;
      st[0].y <= '0;
      st[0].z <= eul_rot_pkg::ZW'(zp[61:31]);
      st[0].quad <= t[31:30];
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        st[i+1].quad <= st[i].quad;
        if (!st[i].z[eul_rot_pkg::ZW-1]) begin
          st[i+1].x <= st[i].x - (st[i].y >>> i);
          st[i+1].y <= st[i].y + (st[i].x >>> i);
          st[i+1].z <= st[i].z - eul_rot_pkg::atan_q30(i);
        end else begin
          st[i+1].x <= st[i].x + (st[i].y >>> i);
          st[i+1].y <= st[i].y - (st[i].x >>> i);
          st[i+1].z <= st[i].z + eul_rot_pkg::atan_q30(i);
        end
      end
    end
  end

  assign cc = eul_rot_pkg::q30_to_frac(st[N].x);
  assign ss = eul_rot_pkg::q30_to_frac(st[N].y);

  always_ff @(posedge clk) begin
    if (en) begin
      case (st[N].quad)
        2'd0: begin sc.c <= cc; sc.s <= ss; end
        2'd1: begin sc.c <= -ss; sc.s <= cc; end
        2'd2: begin sc.c <= -cc; sc.s <= -ss; end
        default: begin sc.c <= ss; sc.s <= -cc; end
      endcase
    end
  end
endmodule

@@ rtl/eul_rot_matrix.sv @@
// Matrix products: two multiply stages, then sum and clamp stage.
module eul_rot_matrix (
  input  logic              clk,
  input  logic              en,
  input  eul_rot_pkg::sc_t  sx_cx,
  input  eul_rot_pkg::sc_t  sy_cy,
  input  eul_rot_pkg::sc_t  sz_cz,
  output eul_rot_pkg::q_t   m [9]
);
  localparam int SW = eul_rot_pkg::OUT_BITS + 2;
  eul_rot_pkg::q_t cx, sx, cy, sy, cz, sz;
  eul_rot_pkg::q_t czsx, cxsz, sxsz, cxcz, sxsy, cxsy, cycz, cysz, cysx, cxcy;
  eul_rot_pkg::q_t sy1, sz1, sy2;
  eul_rot_pkg::q_t b01, b02, b11, b12, p00, p10, p21, p22;
  eul_rot_pkg::q_t c01, c02, c11, c12;

  assign cx = sx_cx.c; assign sx = sx_cx.s;
  assign cy = sy_cy.c; assign sy = sy_cy.s;
  assign cz = sz_cz.c; assign sz = sz_cz.s;

  always_ff @(posedge clk) begin
    if (en) begin
      czsx <= eul_rot_pkg::mulq(cz, sx);
      cxsz <= eul_rot_pkg::mulq(cx, sz);
      sxsz <= eul_rot_pkg::mulq(sx, sz);
      cxcz <= eul_rot_pkg::mulq(cx, cz);
      sxsy <= eul_rot_pkg::mulq(sx, sy);
      cxsy <= eul_rot_pkg::mulq(cx, sy);
      cycz <= eul_rot_pkg::mulq(cy, cz);
      cysz <= eul_rot_pkg::mulq(cy, sz);
      cysx <= eul_rot_pkg::mulq(cy, sx);
      cxcy <= eul_rot_pkg::mulq(cx, cy);
      sy1 <= sy;
      sz1 <= sz;
      b01 <= eul_rot_pkg::mulq(czsx, sy1);
      b02 <= eul_rot_pkg::mulq(cxcz, sy1);
      b11 <= eul_rot_pkg::mulq(sxsy, sz1);
      b12 <= eul_rot_pkg::mulq(cxsy, sz1);
      p00 <= cycz;
      p10 <= cysz;
      p21 <= cysx;
      p22 <= cxcy;
      sy2 <= sy1;
      m[0] <= p00;
      m[1] <= eul_rot_pkg::sat_sum(SW'(b01) + SW'(c01));
      m[2] <= eul_rot_pkg::sat_sum(SW'(c02) - SW'(b02));
      m[3] <= eul_rot_pkg::sat_sum(-SW'(p10));
      m[4] <= eul_rot_pkg::sat_sum(SW'(c11) - SW'(b11));
      m[5] <= eul_rot_pkg::sat_sum(SW'(c12) + SW'(b12));
      m[6] <= sy2;
      m[7] <= eul_rot_pkg::sat_sum(-SW'(p21));
      m[8] <= p22;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c01 <= cxsz;
      c02 <= sxsz;
      c11 <= cxcz;
      c12 <= czsx;
    end
  end
endmodule

@@ rtl/euler_angles_to_rotation_matrix_unit.sv @@
// Channel | Dir | Fields
// in      | in  | pitch_angle, yaw_angle, roll_angle (16b binary angles)
// out     | out | r00..r22 (16b signed Q1.14, clamped to +-1)
// One item per cycle while out does not stall; stages: setup, 30 CORDIC rotations,
// quadrant, two multiply stages and a sum/clamp stage.
// The whole pipeline advances together; when out stalls with a valid
// item at its end, everything holds and in.ready drops.
// rst clears valid bits only.
module euler_angles_to_rotation_matrix_unit (
  input  logic clk,
  input  logic rst,
  eul_rot_in_if.sink    in_ch,
  eul_rot_out_if.source out_ch
);
  localparam int LAT = eul_rot_pkg::CORDIC_STEPS + 5;

  logic [LAT-1:0] vld;
  logic en;
  eul_rot_pkg::sc_t scx, scy, scz;
  eul_rot_pkg::q_t m [9];

  assign en = !vld[LAT-1] || out_ch.ready;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], in_ch.valid};
    end
  end

  eul_rot_cordic u_x (.clk, .en, .angle(in_ch.pitch_angle), .sc(scx));
  eul_rot_cordic u_y (.clk, .en, .angle(in_ch.yaw_angle), .sc(scy));
  eul_rot_cordic u_z (.clk, .en, .angle(in_ch.roll_angle), .sc(scz));

  eul_rot_matrix u_m (.clk, .en, .sx_cx(scx), .sy_cy(scy), .sz_cz(scz), .m);

  assign out_ch.valid = vld[LAT-1];
  assign out_ch.r00 = m[0];
  assign out_ch.r01 = m[1];
  assign out_ch.r02 = m[2];
  assign out_ch.r10 = m[3];
  assign out_ch.r11 = m[4];
  assign out_ch.r12 = m[5];
  assign out_ch.r20 = m[6];
  assign out_ch.r21 = m[7];
  assign out_ch.r22 = m[8];
endmodule
